@@ hw/rtl/rhls_pkg.sv @@
// rhls_pkg: types, constants and the divider step for the rgb to hls converter
// no dependencies; imported by rgb_to_hls_convert
package rhls_pkg;

    localparam int unsigned CH_W    = 8;
    localparam int unsigned HUE_W   = 15;
    localparam int unsigned SUM_W   = 9;
    localparam int unsigned SAT_W   = 8;
    localparam int unsigned Q_W     = 12;   // hue quotient bits, 3840 fits
    localparam int unsigned REM_W   = 20;   // 3840 * 255 fits

    localparam logic [HUE_W-1:0] HUE_FULL  = 15'd23040;  // 360 degrees
    localparam logic [HUE_W-1:0] HUE_GREEN = 15'd7680;   // 120 degrees
    localparam logic [HUE_W-1:0] HUE_BLUE  = 15'd15360;  // 240 degrees
    localparam logic [SUM_W-1:0] SUM_FULL  = 9'd510;
    localparam logic [SUM_W-1:0] SUM_HALF  = 9'd255;

    typedef enum logic [1:0] {
        MAX_RED,
        MAX_GREEN,
        MAX_BLUE
    } max_sel_t;

    // one item inside the division pipeline, both quotients run side by side
    typedef struct packed {
        logic [REM_W-1:0] hue_rem;
        logic [CH_W-1:0]  hue_den;
        logic [Q_W-1:0]   hue_q;
        logic [REM_W-1:0] sat_rem;
        logic [CH_W-1:0]  sat_den;
        logic [Q_W-1:0]   sat_q;
        logic             hue_neg;
        max_sel_t         sel;
        logic             gray;
        logic [SUM_W-1:0] sum;
    } div_item_t;

    // one restoring division step at quotient bit bitpos
    function automatic div_item_t div_step(input div_item_t x, input int unsigned bitpos);
        div_item_t        y;
        logic [REM_W-1:0] hd;
        logic [REM_W-1:0] sd;
        y  = x;
        hd = REM_W'(x.hue_den) << bitpos;
        sd = REM_W'(x.sat_den) << bitpos;
        if (x.hue_rem >= hd)
        begin
            y.hue_rem        = x.hue_rem - hd;
            y.hue_q[bitpos]  = 1'b1;
        end
        if (x.sat_rem >= sd)
        begin
            y.sat_rem        = x.sat_rem - sd;
            y.sat_q[bitpos]  = 1'b1;
        end
        return y;
    endfunction

endpackage

@@ hw/rtl/rgb_to_hls_convert.sv @@
// rgb_to_hls_convert: pipelined rgb pixel to hue, doubled lightness, saturation
// depends on rhls_pkg for types, constants and the division step
//
// Takes one 8-bit rgb pixel per clock while in_stall is low and gives one result per
// pixel, in order. One stage finds max, min and the hue difference, one forms the
// numerators and divisors, twelve stages run a restoring division one quotient bit
// per stage (hue and saturation in parallel), and the last stage builds the hue and
// registers the outputs.
// Every stage holds its own valid bit, so a stall on the output fills bubbles
// first and the input is stalled only when all stages are occupied.
// Hue is in 1/64 degree (0..23039), lightness_x2 is max+min, saturation 0..255.
module rgb_to_hls_convert
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rhls_pkg::CH_W-1:0]         red,
    input  logic [rhls_pkg::CH_W-1:0]         green,
    input  logic [rhls_pkg::CH_W-1:0]         blue,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rhls_pkg::HUE_W-1:0]        hue,
    output logic [rhls_pkg::SUM_W-1:0]        lightness_x2,
    output logic [rhls_pkg::SAT_W-1:0]        saturation
);
    import rhls_pkg::*;

    // stage a: max/min and channel difference
    logic             a_valid_reg;
    max_sel_t         a_sel_reg,   a_sel_next;
    logic [SUM_W-1:0] a_sum_reg,   a_sum_next;
    logic [CH_W-1:0]  a_delta_reg, a_delta_next;
    logic [CH_W-1:0]  a_mag_reg,   a_mag_next;
    logic             a_neg_reg,   a_neg_next;

    // stage b: numerators and divisors
    logic             b_valid_reg;
    div_item_t        b_reg, b_next;

    // division stages
    logic             d_valid_reg [Q_W];
    div_item_t        d_reg       [Q_W];

    // output stage
    logic             out_valid_reg;
    logic [HUE_W-1:0] hue_reg, hue_next;
    logic [SUM_W-1:0] light_reg;
    logic [SAT_W-1:0] sat_reg;

    logic             en_a, en_b, en_out;
    logic             en_d [Q_W];

    // a stage loads when it is empty or its content moves on
    always_comb
    begin
        en_out = !out_valid_reg || !out_stall;
        en_d[Q_W-1] = !d_valid_reg[Q_W-1] || en_out;
        for (int k = Q_W - 2; k >= 0; k--)
        begin
            en_d[k] = !d_valid_reg[k] || en_d[k+1];
        end
        en_b = !b_valid_reg || en_d[0];
        en_a = !a_valid_reg || en_b;
    end

    assign in_stall = !en_a;

    // stage a logic
    always_comb
    begin
        logic [CH_W-1:0] mx, mn, pa, pb;
        if (red >= green && red >= blue)
        begin
            a_sel_next = MAX_RED;
            mx = red;
            pa = green;
            pb = blue;
        end
        else if (green >= blue)
        begin
            a_sel_next = MAX_GREEN;
            mx = green;
            pa = blue;
            pb = red;
        end
        else
        begin
            a_sel_next = MAX_BLUE;
            mx = blue;
            pa = red;
            pb = green;
        end
        mn = red;
        if (green < mn)
        begin
            mn = green;
        end
        if (blue < mn)
        begin
            mn = blue;
        end
        a_sum_next   = SUM_W'(mx) + SUM_W'(mn);
        a_delta_next = mx - mn;
        a_neg_next   = pa < pb;
        a_mag_next   = (pa >= pb) ? (pa - pb) : (pb - pa);
    end

    // stage b logic
    always_comb
    begin
        logic [SUM_W-1:0] den;
        b_next = '0;
        // 3840 * mag and 255 * delta as shift and subtract
        b_next.hue_rem = (REM_W'(a_mag_reg) << 12) - (REM_W'(a_mag_reg) << 8);
        b_next.sat_rem = (REM_W'(a_delta_reg) << 8) - REM_W'(a_delta_reg);
        b_next.hue_den = a_delta_reg;
        den = (a_sum_reg <= SUM_HALF) ? a_sum_reg : (SUM_FULL - a_sum_reg);
        b_next.sat_den = den[CH_W-1:0];
        b_next.hue_neg = a_neg_reg;
        b_next.sel     = a_sel_reg;
        b_next.gray    = (a_delta_reg == '0);
        b_next.sum     = a_sum_reg;
    end

    // output stage: turn the quotient into a wrapped hue
    always_comb
    begin
        div_item_t        x;
        logic [HUE_W-1:0] q;
        logic [HUE_W-1:0] base;
        logic [HUE_W-1:0] nz;
        x    = d_reg[Q_W-1];
        q    = HUE_W'(x.hue_q);
        nz   = HUE_W'(x.hue_rem != '0);
        base = (x.sel == MAX_GREEN) ? HUE_GREEN : HUE_BLUE;
        if (x.gray)
        begin
            hue_next = '0;
        end
        else if (x.sel == MAX_RED)
        begin
            // truncation toward zero, then wrap a negative angle
            hue_next = (x.hue_neg && q != '0) ? (HUE_FULL - q) : q;
        end
        else
        begin
            // offset keeps the exact value positive, so floor it
            hue_next = x.hue_neg ? (base - q - nz) : (base + q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < Q_W; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en_a)
            begin
                a_valid_reg <= in_valid;
            end
            if (en_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (en_d[0])
            begin
                d_valid_reg[0] <= b_valid_reg;
            end
            for (int k = 1; k < Q_W; k++)
            begin
                if (en_d[k])
                begin
                    d_valid_reg[k] <= d_valid_reg[k-1];
                end
            end
            if (en_out)
            begin
                out_valid_reg <= d_valid_reg[Q_W-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            a_sel_reg   <= a_sel_next;
            a_sum_reg   <= a_sum_next;
            a_delta_reg <= a_delta_next;
            a_mag_reg   <= a_mag_next;
            a_neg_reg   <= a_neg_next;
        end
        if (en_b)
        begin
            b_reg <= b_next;
        end
        if (en_d[0])
        begin
            d_reg[0] <= div_step(b_reg, Q_W - 1);
        end
        for (int k = 1; k < Q_W; k++)
        begin
            if (en_d[k])
            begin
                d_reg[k] <= div_step(d_reg[k-1], Q_W - 1 - k);
            end
        end
        if (en_out)
        begin
            hue_reg   <= hue_next;
            light_reg <= d_reg[Q_W-1].sum;
            sat_reg   <= d_reg[Q_W-1].gray ? '0 : d_reg[Q_W-1].sat_q[SAT_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign hue          = hue_reg;
    assign lightness_x2 = light_reg;
    assign saturation   = sat_reg;

    // input backs up only when every stage up to the output holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && a_valid_reg && b_valid_reg))
        else $error("input stalled with a free stage");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hue < HUE_FULL))
        else $error("hue out of range");

    // a colored pixel always has nonzero saturation
    a_gray_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturation == '0) |-> (hue == '0))
        else $error("zero saturation with nonzero hue");

    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lightness_x2 <= SUM_FULL))
        else $error("lightness out of range");

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking bench for rgb_to_hls_convert, directed and random pixels with stalls
// depends on rhls_pkg for widths and hue constants, and on the rgb_to_hls_convert rtl
module tb;
    import rhls_pkg::*;

    localparam int N_PIXELS     = 550;
    localparam int N_DIRECTED   = 20;
    localparam int CALM_FROM    = 470;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int MAX_REPORTS  = 10;

    // hue constants as signed ints so the arithmetic below stays signed
    localparam int HUE_SEXTANT  = 3840;
    localparam int HUE_GREEN_I  = int'(HUE_GREEN);
    localparam int HUE_BLUE_I   = int'(HUE_BLUE);
    localparam int HUE_FULL_I   = int'(HUE_FULL);

    class hls_scoreboard;
        typedef struct {
            logic [3*CH_W-1:0] rgb;
            logic [HUE_W-1:0]  hue;
            logic [SUM_W-1:0]  light2;
            logic [SAT_W-1:0]  sat;
        } hls_t;

        hls_t expected_hls[$];
        int   failures;

        function hls_t convert_pixel(logic [CH_W-1:0] r8, logic [CH_W-1:0] g8,
                                     logic [CH_W-1:0] b8);
            hls_t res;
            int   r, g, b, hi, lo, delta, sum, h, s;
            r = int'(r8);
            g = int'(g8);
            b = int'(b8);
            hi = r;
            if (g > hi) hi = g;
            if (b > hi) hi = b;
            lo = r;
            if (g < lo) lo = g;
            if (b < lo) lo = b;
            sum   = hi + lo;
            delta = hi - lo;
            if (delta == 0)
            begin
                h = 0;
                s = 0;
            end
            else
            begin
                if (sum <= 255)
                    s = (255 * delta) / sum;
                else
                    s = (255 * delta) / (510 - sum);
                // signed division truncates toward zero; ties resolve red, then green
                if (hi == r)
                    h = (HUE_SEXTANT * (g - b)) / delta;
                else if (hi == g)
                    h = (HUE_GREEN_I * delta + HUE_SEXTANT * (b - r)) / delta;
                else
                    h = (HUE_BLUE_I * delta + HUE_SEXTANT * (r - g)) / delta;
                if (h < 0)
                    h = h + HUE_FULL_I;
            end
            res.rgb    = {r8, g8, b8};
            res.hue    = h[HUE_W-1:0];
            res.light2 = sum[SUM_W-1:0];
            res.sat    = s[SAT_W-1:0];
            return res;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void note_pixel(logic [CH_W-1:0] r8, logic [CH_W-1:0] g8,
                                 logic [CH_W-1:0] b8);
            expected_hls.push_back(convert_pixel(r8, g8, b8));
        endfunction

        function void check_result(logic [HUE_W-1:0] h, logic [SUM_W-1:0] l2,
                                   logic [SAT_W-1:0] s);
            hls_t e;
            if (expected_hls.size() == 0)
            begin
                flag($sformatf("unexpected item: hue %0d lightness_x2 %0d saturation %0d",
                               h, l2, s));
                return;
            end
            e = expected_hls.pop_front();
            if (h !== e.hue || l2 !== e.light2 || s !== e.sat)
                flag($sformatf({"mismatch rgb %06h: hue %0d/%0d lightness_x2 %0d/%0d ",
                                "saturation %0d/%0d (expected/actual)"},
                               e.rgb, e.hue, h, e.light2, l2, e.sat, s));
        endfunction
    endclass

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [CH_W-1:0]   red          = '0;
    logic [CH_W-1:0]   green        = '0;
    logic [CH_W-1:0]   blue         = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [HUE_W-1:0]  hue;
    logic [SUM_W-1:0]  lightness_x2;
    logic [SAT_W-1:0]  saturation;

    logic              hold_off     = 1'b0;
    logic              calm         = 1'b0;
    int                pixels_sent  = 0;
    int                cycle_count  = 0;

    hls_scoreboard     hls_check    = new;

    // black, white, gray, primaries, ties, hue wrap, sum boundaries, small deltas
    bit [3*CH_W-1:0] directed_px [N_DIRECTED] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001,
        24'h010000, 24'hFEFFFF, 24'hC83864, 24'hFF0100, 24'h64C832,
        24'h1E0AC8, 24'h0A1EC8, 24'h7F8080, 24'hAA55AA, 24'h01FEFF
    };

    rgb_to_hls_convert dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hue          (hue),
        .lightness_x2 (lightness_x2),
        .saturation   (saturation)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // offer one pixel and hold it until the block takes it
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        red      <= r;
        green    <= g;
        blue     <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        hls_check.note_pixel(r, g, b);
        pixels_sent++;
        if (pixels_sent >= CALM_FROM)
            calm <= 1'b1;
    endtask

    task automatic pause_pixels(input int n);
        in_valid <= 1'b0;
        red      <= CH_W'($urandom);
        green    <= CH_W'($urandom);
        blue     <= CH_W'($urandom);
        repeat (n)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [CH_W-1:0] c [3];
        logic [CH_W-1:0] base;
        int              mode;
        int              pick;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_px[i])
        begin
            if ($urandom_range(0, 3) == 0)
                pause_pixels($urandom_range(1, 3));
            send_pixel(directed_px[i][23:16], directed_px[i][15:8], directed_px[i][7:0]);
        end

        for (int i = N_DIRECTED; i < N_PIXELS; i++)
        begin
            mode = $urandom_range(0, 7);
            if (mode < 4)
            begin
                foreach (c[k])
                    c[k] = CH_W'($urandom);
            end
            else if (mode < 6)
            begin
                // near gray: tiny deltas stress the divider
                base = CH_W'($urandom);
                foreach (c[k])
                    c[k] = (base > 252) ? CH_W'($urandom_range(252, 255))
                                        : CH_W'($urandom_range(int'(base), int'(base) + 3));
            end
            else if (mode == 6)
            begin
                // two equal channels to exercise the max tie order
                base = CH_W'($urandom);
                pick = $urandom_range(0, 2);
                foreach (c[k])
                    c[k] = (k == pick) ? CH_W'($urandom) : base;
            end
            else
            begin
                foreach (c[k])
                begin
                    pick = $urandom_range(0, 2);
                    c[k] = (pick == 0) ? '0 : (pick == 1) ? '1 : CH_W'($urandom);
                end
            end
            if (!calm && $urandom_range(0, 3) == 0)
                pause_pixels($urandom_range(1, 3));
            send_pixel(c[0], c[1], c[2]);
        end
        in_valid <= 1'b0;

        while (hls_check.expected_hls.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (hls_check.failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                hls_check.check_result(hue, lightness_x2, saturation);
            if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 3);
            out_stall <= hold_off || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // long output stall so the pipeline fills and pushes back on the input
    initial
    begin : hold_off_ctl
        wait (pixels_sent >= HOLD_AT);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_off <= 1'b0;
    end

endmodule
